>>> rtl/core/assert_macros.svh
// Assertion macros shared by the button debounce and click classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check on every rising edge once reset is released.
`define BDCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every rising edge, reset included.
`define BDCC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDCC_ASSERT(label, clk, rst_n, prop, msg)
`define BDCC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/bdcc_pkg.sv
// Shared types, constants and helpers of the button debounce and click classifier.
package bdcc_pkg;

    localparam int BUTTONS_DEFAULT   = 8;
    localparam int TIME_BITS_DEFAULT = 32;

    localparam int BTN_W      = 3;
    localparam int NOW_W      = 32;
    localparam int CODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MS_W       = 16;
    localparam int ENABLE_W   = 8;

    // Event queue sizing.
    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_PTR_W = $clog2(EVQ_DEPTH);
    localparam int EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

    // Register reset values.
    localparam logic [MS_W-1:0]     DEBOUNCE_RESET     = 16'd50;
    localparam logic [MS_W-1:0]     LONG_PRESS_RESET   = 16'd1000;
    localparam logic [MS_W-1:0]     DOUBLE_CLICK_RESET = 16'd400;
    localparam logic                IDLE_LEVEL_RESET   = 1'b1;
    localparam logic [ENABLE_W-1:0] ENABLE_RESET       = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE     = 3'd0,
        REG_LONG_PRESS   = 3'd1,
        REG_DOUBLE_CLICK = 3'd2,
        REG_IDLE_LEVEL   = 3'd3,
        REG_ENABLE       = 3'd4
    } reg_index_t;

    typedef enum logic [CODE_W-1:0] {
        EV_PRESS   = 3'd0,
        EV_RELEASE = 3'd1,
        EV_CLICK   = 3'd2,
        EV_DOUBLE  = 3'd3,
        EV_LONG    = 3'd4
    } event_code_t;

    typedef struct packed {
        logic [BTN_W-1:0] button_index;
        logic             level;
        logic [NOW_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic [BTN_W-1:0]  event_button;
        logic [CODE_W-1:0] event_code;
        logic              last_event;
    } event_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic [MS_W-1:0]     debounce_ms;
        logic [MS_W-1:0]     long_press_ms;
        logic [MS_W-1:0]     double_click_ms;
        logic                idle_level;
        logic [ENABLE_W-1:0] button_enable;
    } cfg_t;

    // Events produced by one sample, pushed into the queue together.
    typedef struct packed {
        logic   first_valid;
        event_t first;
        logic   second_valid;
        event_t second;
    } evq_push_t;

    // Bits of one per-button state entry: raw, stable and three timestamps.
    function automatic int entry_width(input int time_bits);
        return 2 + 3 * time_bits;
    endfunction

endpackage

>>> rtl/core/bdcc_if.sv
// Valid/ready channel interfaces for samples, events and register writes.
interface bdcc_sample_if;
    logic               valid;
    logic               ready;
    bdcc_pkg::sample_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bdcc_event_if;
    logic             valid;
    logic             ready;
    bdcc_pkg::event_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bdcc_cfg_if;
    logic                 valid;
    logic                 ready;
    bdcc_pkg::cfg_write_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/button_debounce_click_classifier.sv
// Top level of the button debounce and click classifier.
// Each sample transaction carries a button index, the raw pin level and a wrapping
// millisecond timestamp. A level that stays unchanged for strictly more than
// debounce_ms becomes the stable level; leaving the idle level emits a press event,
// returning to it emits a release event followed by one of long press, double click
// or click (long press wins over double click). Samples for disabled buttons, or
// indexes at or above BUTTONS, are taken and dropped without effect. Per-button
// state lives in one memory read at accept and written back in the cycle after; a
// sample for the same button right behind it takes the written entry from a
// forwarding register. Entries never written read as the reset state through a
// bank of valid flags cleared at reset, so no clearing pass is needed and the block
// takes samples right after reset. Events leave through a four-entry queue, the
// first one reaching it from the registered update stage. A sample is taken while the
// queue holds at most two events counting the two reserved for the sample in the
// update stage, so a sample can follow one in the update stage only while the
// queue is empty; the queue depth bounds the sample rate. Register writes are
// always taken, and are meant to arrive only while no sample is in flight.
`include "assert_macros.svh"

module button_debounce_click_classifier #(
    parameter int BUTTONS   = bdcc_pkg::BUTTONS_DEFAULT,
    parameter int TIME_BITS = bdcc_pkg::TIME_BITS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    bdcc_sample_if.sink   samples,
    bdcc_event_if.source  events,
    bdcc_cfg_if.sink      cfg
);

    localparam int AW    = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int EW    = bdcc_pkg::entry_width(TIME_BITS);
    localparam int OCC_W = bdcc_pkg::EVQ_CNT_W + 1;

    bdcc_pkg::cfg_t      regs;
    bdcc_pkg::evq_push_t push;
    logic                accept;
    logic                busy;
    logic [bdcc_pkg::EVQ_CNT_W-1:0] fill;
    logic [OCC_W-1:0]    occupancy;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [EW-1:0]       rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data;

    // Reserve two queue slots for the sample sitting in the update stage.
    assign occupancy     = {1'b0, fill} + (busy ? OCC_W'(2) : OCC_W'(0));
    assign samples.ready = (occupancy <= OCC_W'(bdcc_pkg::EVQ_DEPTH - 2));
    assign accept        = samples.valid && samples.ready;

    bdcc_cfg_regs u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    bdcc_state_ram #(
        .WIDTH (EW),
        .DEPTH (BUTTONS)
    ) u_ram
    (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bdcc_update #(
        .BUTTONS   (BUTTONS),
        .TIME_BITS (TIME_BITS)
    ) u_update
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (regs),
        .accept  (accept),
        .smp     (samples.payload),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .push    (push),
        .busy    (busy)
    );

    bdcc_event_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .events (events),
        .fill   (fill)
    );

    // Update stage only ever holds a sample accepted on the previous edge.
    `BDCC_ASSERT(a_busy_from_accept, clk, rst_n, busy |-> $past(accept), "update stage busy without accepted sample")
    // Only a release is followed by another event of the same sample.
    `BDCC_ASSERT(a_nonlast_release, clk, rst_n, (events.valid && !events.payload.last_event) |-> (events.payload.event_code == bdcc_pkg::EV_RELEASE), "non-final event is not a release")
    // The class event is queued together with its release, so it follows at once.
    `BDCC_ASSERT(a_class_follows, clk, rst_n, (events.valid && events.ready && !events.payload.last_event) |=> events.valid, "class event missing after release")

endmodule

>>> rtl/core/bdcc_cfg_regs.sv
// Configuration register file written through the register write channel.
module bdcc_cfg_regs
(
    input  logic           clk,
    input  logic           rst_n,
    bdcc_cfg_if.sink       cfg,
    output bdcc_pkg::cfg_t regs
);

    bdcc_pkg::cfg_t regs_reg;
    bdcc_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                bdcc_pkg::REG_DEBOUNCE:     regs_next.debounce_ms     = cfg.payload.data;
                bdcc_pkg::REG_LONG_PRESS:   regs_next.long_press_ms   = cfg.payload.data;
                bdcc_pkg::REG_DOUBLE_CLICK: regs_next.double_click_ms = cfg.payload.data;
                bdcc_pkg::REG_IDLE_LEVEL:   regs_next.idle_level      = cfg.payload.data[0];
                bdcc_pkg::REG_ENABLE:
                    regs_next.button_enable = cfg.payload.data[bdcc_pkg::ENABLE_W-1:0];
                default:
                begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.debounce_ms     <= bdcc_pkg::DEBOUNCE_RESET;
            regs_reg.long_press_ms   <= bdcc_pkg::LONG_PRESS_RESET;
            regs_reg.double_click_ms <= bdcc_pkg::DOUBLE_CLICK_RESET;
            regs_reg.idle_level      <= bdcc_pkg::IDLE_LEVEL_RESET;
            regs_reg.button_enable   <= bdcc_pkg::ENABLE_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

>>> rtl/core/bdcc_state_ram.sv
// Single-port-write, registered-read memory for the per-button state.
module bdcc_state_ram #(
    parameter int WIDTH = 98,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/bdcc_update.sv
// Update stage: merges stored state, debounces, classifies and writes back.
module bdcc_update #(
    parameter int BUTTONS   = bdcc_pkg::BUTTONS_DEFAULT,
    parameter int TIME_BITS = bdcc_pkg::TIME_BITS_DEFAULT,
    localparam int AW       = (BUTTONS > 1) ? $clog2(BUTTONS) : 1,
    localparam int EW       = bdcc_pkg::entry_width(TIME_BITS)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  bdcc_pkg::cfg_t      cfg,
    input  logic                accept,
    input  bdcc_pkg::sample_t   smp,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    input  logic [EW-1:0]       rd_data,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [EW-1:0]       wr_data,
    output bdcc_pkg::evq_push_t push,
    output logic                busy
);

    typedef struct packed {
        logic                 raw;
        logic                 stable;
        logic [TIME_BITS-1:0] change_ms;
        logic [TIME_BITS-1:0] press_ms;
        logic [TIME_BITS-1:0] release_ms;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        raw:        bdcc_pkg::IDLE_LEVEL_RESET,
        stable:     bdcc_pkg::IDLE_LEVEL_RESET,
        change_ms:  '0,
        press_ms:   '0,
        release_ms: '0
    };

    // control
    logic                          s1_valid_reg;
    logic [BUTTONS-1:0]            vld_reg;
    // payload
    logic [bdcc_pkg::BTN_W-1:0]    s1_btn_reg;
    logic                          s1_level_reg;
    logic [TIME_BITS-1:0]          s1_now_reg;
    logic                          rd_vld_reg;
    logic                          fwd_hit_reg;
    entry_t                        fwd_entry_reg;

    logic [AW-1:0]                 in_addr;
    logic                          in_enabled;
    logic [AW-1:0]                 s1_addr;
    entry_t                        cur;
    entry_t                        entry_next;
    logic [TIME_BITS-1:0]          since_change;
    logic [TIME_BITS-1:0]          held_for;
    logic [TIME_BITS-1:0]          gap;
    logic                          settled;
    logic                          flip;
    logic                          is_release;
    bdcc_pkg::event_code_t         class_code;

    assign in_addr    = AW'(smp.button_index);
    assign in_enabled = (int'(smp.button_index) < BUTTONS)
                        && cfg.button_enable[smp.button_index];
    assign s1_addr    = AW'(s1_btn_reg);

    assign rd_en   = accept;
    assign rd_addr = in_addr;
    assign busy    = s1_valid_reg;

    // Take the entry just written when the previous sample hit the same button.
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur = fwd_entry_reg;
        end
        else if (rd_vld_reg)
        begin
            cur = entry_t'(rd_data);
        end
        else
        begin
            cur = ENTRY_RESET;
        end
    end

    assign since_change = s1_now_reg - cur.change_ms;
    assign held_for     = s1_now_reg - cur.press_ms;
    assign gap          = cur.press_ms - cur.release_ms;

    // A raw change restarts the timer, so it can never settle in the same sample.
    assign settled    = (s1_level_reg == cur.raw)
                        && (since_change > TIME_BITS'(cfg.debounce_ms));
    assign flip       = settled && (s1_level_reg != cur.stable);
    assign is_release = (s1_level_reg == cfg.idle_level);

    always_comb
    begin
        if (held_for > TIME_BITS'(cfg.long_press_ms))
        begin
            class_code = bdcc_pkg::EV_LONG;
        end
        else if (gap < TIME_BITS'(cfg.double_click_ms))
        begin
            class_code = bdcc_pkg::EV_DOUBLE;
        end
        else
        begin
            class_code = bdcc_pkg::EV_CLICK;
        end
    end

    always_comb
    begin
        entry_next     = cur;
        entry_next.raw = s1_level_reg;
        if (s1_level_reg != cur.raw)
        begin
            entry_next.change_ms = s1_now_reg;
        end
        if (flip)
        begin
            entry_next.stable = s1_level_reg;
            if (is_release)
            begin
                entry_next.release_ms = s1_now_reg;
            end
            else
            begin
                entry_next.press_ms = s1_now_reg;
            end
        end
    end

    always_comb
    begin
        push.first_valid         = s1_valid_reg && flip;
        push.first.event_button  = s1_btn_reg;
        push.first.event_code    = is_release ? bdcc_pkg::EV_RELEASE : bdcc_pkg::EV_PRESS;
        push.first.last_event    = !is_release;
        push.second_valid        = s1_valid_reg && flip && is_release;
        push.second.event_button = s1_btn_reg;
        push.second.event_code   = class_code;
        push.second.last_event   = 1'b1;
    end

    assign wr_en   = s1_valid_reg;
    assign wr_addr = s1_addr;
    assign wr_data = EW'(entry_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            vld_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= accept && in_enabled;
            if (s1_valid_reg)
            begin
                vld_reg[s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_btn_reg   <= smp.button_index;
            s1_level_reg <= smp.level;
            s1_now_reg   <= smp.now_ms[TIME_BITS-1:0];
            rd_vld_reg   <= vld_reg[in_addr];
            fwd_hit_reg  <= s1_valid_reg && (s1_addr == in_addr);
        end
        if (s1_valid_reg)
        begin
            fwd_entry_reg <= entry_next;
        end
    end

endmodule

>>> rtl/core/bdcc_event_queue.sv
// Small event queue that takes up to two events a cycle and drains one while the event side is ready.
`include "assert_macros.svh"

module bdcc_event_queue
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  bdcc_pkg::evq_push_t                push,
    bdcc_event_if.source                       events,
    output logic [bdcc_pkg::EVQ_CNT_W-1:0]     fill
);

    localparam int PW = bdcc_pkg::EVQ_PTR_W;
    localparam int CW = bdcc_pkg::EVQ_CNT_W;

    bdcc_pkg::event_t mem_reg [bdcc_pkg::EVQ_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [1:0]       n_push;
    logic             pop;

    assign events.valid   = (count_reg != '0);
    assign events.payload = mem_reg[rd_ptr_reg];
    assign fill           = count_reg;

    assign pop    = events.valid && events.ready;
    assign n_push = {1'b0, push.first_valid} + {1'b0, push.second_valid};

    assign wr_ptr_next = wr_ptr_reg + PW'(n_push);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign count_next  = count_reg + CW'(n_push) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid)
        begin
            mem_reg[wr_ptr_reg + PW'(1)] <= push.second;
        end
    end

    `BDCC_ASSERT_ALWAYS(a_evq_bound, clk, count_reg <= CW'(bdcc_pkg::EVQ_DEPTH), "event queue overfilled")
    `BDCC_ASSERT(a_evq_pair, clk, rst_n, push.second_valid |-> push.first_valid, "second event without first")
    `BDCC_ASSERT(a_evq_lone, clk, rst_n, (push.first_valid && !push.second_valid) |-> push.first.last_event, "lone event not marked last")

endmodule

>>> bench/click_check_pkg.sv
// Scoreboard class that predicts button events from accepted samples and checks them.
package click_check_pkg;
    import bdcc_pkg::*;

    localparam int BUTTON_COUNT = 8;
    localparam int REPORT_LIMIT = 10;

    class click_scoreboard;
        logic [MS_W-1:0]     debounce_ms;
        logic [MS_W-1:0]     long_press_ms;
        logic [MS_W-1:0]     double_click_ms;
        logic                idle_level;
        logic [ENABLE_W-1:0] button_enable;

        logic             raw_prev     [BUTTON_COUNT];
        logic             stable_level [BUTTON_COUNT];
        logic [NOW_W-1:0] change_time  [BUTTON_COUNT];
        logic [NOW_W-1:0] press_time   [BUTTON_COUNT];
        logic [NOW_W-1:0] release_time [BUTTON_COUNT];

        event_t pending_events[$];
        int     mismatch_count;

        function new();
            int b;
            debounce_ms     = DEBOUNCE_RESET;
            long_press_ms   = LONG_PRESS_RESET;
            double_click_ms = DOUBLE_CLICK_RESET;
            idle_level      = IDLE_LEVEL_RESET;
            button_enable   = ENABLE_RESET;
            for (b = 0; b < BUTTON_COUNT; b++)
            begin
                raw_prev[b]     = IDLE_LEVEL_RESET;
                stable_level[b] = IDLE_LEVEL_RESET;
                change_time[b]  = '0;
                press_time[b]   = '0;
                release_time[b] = '0;
            end
            mismatch_count = 0;
        endfunction

        function void write_register(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DEBOUNCE:     debounce_ms     = data[MS_W-1:0];
                REG_LONG_PRESS:   long_press_ms   = data[MS_W-1:0];
                REG_DOUBLE_CLICK: double_click_ms = data[MS_W-1:0];
                REG_IDLE_LEVEL:   idle_level      = data[0];
                REG_ENABLE:       button_enable   = data[ENABLE_W-1:0];
                default:          ;
            endcase
        endfunction

        function void push_event(input int b, input event_code_t code, input logic last);
            event_t e;
            e.event_button = BTN_W'(b);
            e.event_code   = code;
            e.last_event   = last;
            pending_events.push_back(e);
        endfunction

        // Debounce the raw level; a new stable level yields press or release plus its class.
        function void take_sample(input sample_t s);
            int               b;
            logic [NOW_W-1:0] held;
            logic [NOW_W-1:0] duration;
            logic [NOW_W-1:0] gap;
            event_code_t      kind;
            b = int'(s.button_index);
            if (!button_enable[b])
                return;
            if (s.level != raw_prev[b])
                change_time[b] = s.now_ms;
            held = s.now_ms - change_time[b];
            if (held > NOW_W'(debounce_ms) && s.level != stable_level[b])
            begin
                stable_level[b] = s.level;
                if (s.level == idle_level)
                begin
                    duration = s.now_ms - press_time[b];
                    gap      = press_time[b] - release_time[b];
                    if (duration > NOW_W'(long_press_ms))
                        kind = EV_LONG;
                    else if (gap < NOW_W'(double_click_ms))
                        kind = EV_DOUBLE;
                    else
                        kind = EV_CLICK;
                    push_event(b, EV_RELEASE, 1'b0);
                    push_event(b, kind, 1'b1);
                    release_time[b] = s.now_ms;
                end
                else
                begin
                    push_event(b, EV_PRESS, 1'b1);
                    press_time[b] = s.now_ms;
                end
            end
            raw_prev[b] = s.level;
        endfunction

        function void check_event(input event_t got);
            event_t want;
            if (pending_events.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected event: button %0d code %0d last %0d",
                             got.event_button, got.event_code, got.last_event);
                return;
            end
            want = pending_events.pop_front();
            if (got.event_button !== want.event_button || got.event_code !== want.event_code ||
                got.last_event !== want.last_event)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display({"event mismatch: expected button %0d code %0d last %0d, ",
                              "got button %0d code %0d last %0d"},
                             want.event_button, want.event_code, want.last_event,
                             got.event_button, got.event_code, got.last_event);
            end
        endfunction
    endclass

endpackage

>>> bench/tb.sv
// Top of the bench: drives sample and register transactions and checks every event.
module tb;
    import bdcc_pkg::*;
    import click_check_pkg::*;

    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 12;

    logic clk;
    logic rst_n;

    bdcc_sample_if sample_ch ();
    bdcc_event_if  event_ch ();
    bdcc_cfg_if    cfg_ch ();

    click_scoreboard board;

    // Per-button millisecond clock the gestures advance from.
    logic [NOW_W-1:0] btn_clock [BUTTON_COUNT];
    int               items_sent;
    int               no_gap_left;
    bit               hold_off_request;

    button_debounce_click_classifier dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .events  (event_ch),
        .cfg     (cfg_ch)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_enabled();
        int b;
        do
            b = $urandom_range(0, BUTTON_COUNT - 1);
        while (!board.button_enable[b]);
        return b;
    endfunction

    // Aim a press or a release right at a threshold, one either side, or anywhere near it.
    function automatic logic [NOW_W-1:0] pick_target(input logic [MS_W-1:0] limit);
        case ($urandom_range(0, 4))
            0:       return NOW_W'(limit) - 1;
            1:       return NOW_W'(limit);
            2:       return NOW_W'(limit) + 1;
            default: return $urandom_range(0, 2 * limit + 100);
        endcase
    endfunction

    // Offer one sample transaction after an optional gap and hold it until taken.
    task automatic send_sample(input int b, input logic level, input logic [NOW_W-1:0] now);
        sample_t s;
        int      gap;
        s.button_index = BTN_W'(b);
        s.level        = level;
        s.now_ms       = now;
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            gap = 0;
        end
        else
            gap = pick_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.payload <= s;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        if (board.button_enable[b])
            items_sent++;
        board.take_sample(s);
    endtask

    // Drop valid and wait until every predicted event has come back.
    task automatic wait_until_idle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_events.size() != 0)
            @(posedge clk);
        // Samples that raise no event may still be in the pipeline.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_register(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write_t w;
        w.index = idx;
        w.data  = data;
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= w;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        board.write_register(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Reprogram all registers once the block has gone quiet. Unused upper data bits get junk.
    task automatic apply_setting(input logic [MS_W-1:0] deb, lng, dbl, input logic idle,
                                 input logic [ENABLE_W-1:0] mask);
        logic [CFG_DATA_W-1:0] junk;
        wait_until_idle();
        junk = CFG_DATA_W'($urandom);
        program_register(REG_DEBOUNCE, deb);
        program_register(REG_LONG_PRESS, lng);
        program_register(REG_DOUBLE_CLICK, dbl);
        program_register(REG_IDLE_LEVEL, {junk[CFG_DATA_W-1:1], idle});
        program_register(REG_ENABLE, {junk[CFG_DATA_W-1:ENABLE_W], mask});
    endtask

    // Move one button to a new level: optional contact bounce, then a sample that
    // confirms the level at anchor + target when that is reachable past the debounce.
    task automatic settle(input int b, input logic level, input logic [NOW_W-1:0] anchor,
                          input logic [NOW_W-1:0] target);
        logic [NOW_W-1:0] t_change;
        logic [NOW_W-1:0] t_reach;
        logic [NOW_W-1:0] t_hit;
        logic [NOW_W-1:0] slack;
        int               bounces;
        int               k;
        t_change = btn_clock[b] + $urandom_range(1, 30);
        if ($urandom_range(0, 3) == 0)
        begin
            bounces = $urandom_range(1, 3);
            for (k = 0; k < bounces; k++)
            begin
                send_sample(b, (k % 2 == 0) ? ~level : level, t_change);
                t_change += $urandom_range(0, 5);
            end
        end
        send_sample(b, level, t_change);
        t_reach = t_change + NOW_W'(board.debounce_ms) + 1;
        // A sample still inside the debounce window, or exactly on its edge.
        if ($urandom_range(0, 1) == 0)
            send_sample(b, level, t_change + $urandom_range(0, board.debounce_ms));
        else if ($urandom_range(0, 2) == 0)
            send_sample(b, level, t_reach - 1);
        slack = anchor + target - t_reach;
        if (slack < 32'd100000)
            t_hit = anchor + target;
        else
            t_hit = t_reach + $urandom_range(0, 3);
        send_sample(b, level, t_hit);
        btn_clock[b] = t_hit;
    endtask

    // Press then release, or finish a press left held; now and then leave a button held.
    task automatic gesture(input int b);
        if (board.stable_level[b] == board.idle_level)
        begin
            settle(b, ~board.idle_level, board.release_time[b],
                   pick_target(board.double_click_ms));
            if ($urandom_range(0, 7) == 0)
                return;
        end
        settle(b, board.idle_level, board.press_time[b], pick_target(board.long_press_ms));
    endtask

    task automatic noise_sample();
        int b;
        b = $urandom_range(0, BUTTON_COUNT - 1);
        if ($urandom_range(0, 1) == 0)
            send_sample(b, 1'($urandom_range(0, 1)), $urandom);
        else
        begin
            btn_clock[b] += $urandom_range(0, 2 * board.debounce_ms + 2);
            send_sample(b, 1'($urandom_range(0, 1)), btn_clock[b]);
        end
    endtask

    task automatic random_phase(input int quota);
        int stop_at;
        int b;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            // Occasional stretch of back-to-back samples.
            if ($urandom_range(0, 49) == 0)
                no_gap_left = $urandom_range(20, 60);
            if ($urandom_range(0, 5) == 0)
                noise_sample();
            else
            begin
                b = pick_enabled();
                // Let a lot of time pass now and then, which also crosses the wrap point.
                if ($urandom_range(0, 39) == 0)
                    btn_clock[b] += $urandom;
                gesture(b);
            end
        end
    endtask

    // Score every event transaction at the edge it is taken.
    always @(posedge clk)
    begin
        if (rst_n && event_ch.valid && event_ch.ready)
            board.check_event(event_ch.payload);
    end

    // Event side: random ready, long open stretches, and one long hold-off on request.
    initial
    begin : event_sink
        int   run;
        logic ready_next;
        event_ch.ready <= 1'b0;
        forever
        begin
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                ready_next = 1'b0;
                run = HOLD_OFF_CYCLES;
            end
            else if ($urandom_range(0, 29) == 0)
            begin
                ready_next = 1'b1;
                run = $urandom_range(100, 200);
            end
            else
            begin
                ready_next = ($urandom_range(0, 2) != 0);
                run = ready_next ? $urandom_range(1, 6) : 1 + pick_gap();
            end
            event_ch.ready <= ready_next;
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int b;
        board = new();
        rst_n = 1'b0;
        sample_ch.valid   <= 1'b0;
        sample_ch.payload <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.payload    <= '0;
        items_sent = 0;
        no_gap_left = 0;
        hold_off_request = 1'b0;
        for (b = 0; b < BUTTON_COUNT; b++)
            btn_clock[b] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All buttons are disabled out of reset: this sample must vanish.
        send_sample(0, 1'b0, 32'd100);
        apply_setting(DEBOUNCE_RESET, LONG_PRESS_RESET, DOUBLE_CLICK_RESET,
                      IDLE_LEVEL_RESET, 8'hFF);

        // Button 0 at default timing: the first press lands exactly on the debounce
        // edge and then one past it.
        send_sample(0, 1'b0, 32'd100);
        send_sample(0, 1'b0, 32'd150);
        send_sample(0, 1'b0, 32'd151);
        // First release counts from a release time of zero: double click.
        send_sample(0, 1'b1, 32'd300);
        send_sample(0, 1'b1, 32'd351);
        // Press well after the release, short hold: plain click.
        send_sample(0, 1'b0, 32'd800);
        send_sample(0, 1'b0, 32'd851);
        send_sample(0, 1'b1, 32'd900);
        send_sample(0, 1'b1, 32'd951);
        // Quick re-press held too long: long press wins over double click.
        send_sample(0, 1'b0, 32'd1000);
        send_sample(0, 1'b0, 32'd1051);
        send_sample(0, 1'b1, 32'd2100);
        send_sample(0, 1'b1, 32'd2151);
        // Button 7 across the timestamp wrap.
        send_sample(7, 1'b0, 32'hFFFF_FFE0);
        send_sample(7, 1'b0, 32'h0000_0020);
        send_sample(7, 1'b1, 32'h0000_0030);
        send_sample(7, 1'b1, 32'h0000_0070);
        // Largest timestamp at the idle level: no change at all.
        send_sample(3, 1'b1, 32'hFFFF_FFFF);
        // Contact bounce on button 1 restarts the debounce window.
        send_sample(1, 1'b0, 32'd10);
        send_sample(1, 1'b1, 32'd20);
        send_sample(1, 1'b0, 32'd30);
        send_sample(1, 1'b0, 32'd60);
        send_sample(1, 1'b0, 32'd81);

        // Lowest thresholds.
        apply_setting(16'd0, 16'd0, 16'd0, 1'b1, 8'hFF);
        random_phase(200);

        // Highest thresholds and an inverted idle level over the stored levels.
        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 8'hA5);
        random_phase(200);

        // Hold the event side off while samples keep coming, so the block stalls its input.
        apply_setting(MS_W'($urandom_range(0, 120)), MS_W'($urandom_range(0, 3000)),
                      MS_W'($urandom_range(0, 1000)), 1'($urandom_range(0, 1)),
                      ENABLE_W'($urandom_range(1, 255)));
        random_phase(100);
        no_gap_left = 40;
        hold_off_request = 1'b1;
        random_phase(100);

        // Pause the sender until everything has drained, then carry on.
        apply_setting(MS_W'($urandom_range(0, 120)), MS_W'($urandom_range(0, 3000)),
                      MS_W'($urandom_range(0, 1000)), 1'($urandom_range(0, 1)),
                      ENABLE_W'($urandom_range(1, 255)));
        random_phase(100);
        wait_until_idle();
        random_phase(100);

        apply_setting(MS_W'($urandom_range(0, 60)), MS_W'($urandom_range(0, 1500)),
                      MS_W'($urandom_range(0, 600)), 1'b1, 8'hFF);
        random_phase(200);

        apply_setting(MS_W'($urandom_range(0, 30)), MS_W'($urandom_range(0, 800)),
                      MS_W'($urandom_range(0, 400)), 1'($urandom_range(0, 1)),
                      ENABLE_W'($urandom_range(1, 255)));
        random_phase(200);

        wait_until_idle();
        if (board.mismatch_count == 0 && board.pending_events.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
